### rtl/ffa_pkg.sv
// ffa_pkg: shared types and constants for the first-fit arena allocator
// used by ffa_ctrl, ffa_dp and first_fit_arena_allocator_core
package ffa_pkg;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_FIT  = 2'd1;
    localparam logic [1:0] ST_BAD_FREE = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // datapath commands
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_INIT,      // write entry 0 from arena size
        CMD_LOAD,      // latch input beat
        CMD_RD,        // issue read at scan index
        CMD_SCAN_CHK,  // compare read data, advance scan index
        CMD_ALLOC_WR,  // write trimmed segment at hit index
        CMD_INS_STEP,  // move entry j-1 to j
        CMD_INS_WR,    // write new free segment
        CMD_FREE_RD,   // latch next neighbour
        CMD_FREE_WR,   // write merged entry
        CMD_REM_STEP   // move entry j+mode to j
    } t_cmd;

    typedef struct packed {
        logic scan_hit;
        logic scan_end;
        logic table_full;
        logic shift_end;
        logic rem_end;
        logic op_free;
        logic is_free_hit;
    } t_stat;

endpackage

### rtl/ffa_ram.sv
// ffa_ram: generic single-write, single-read ram with registered read
// no dependencies
module ffa_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### rtl/ffa_dp.sv
// ffa_dp: segment table datapath (ram, scan/shift index, merge arithmetic)
// depends on ffa_pkg and ffa_ram
module ffa_dp
    import ffa_pkg::*;
#(
    parameter int MAX_SEGMENTS = 128,
    parameter int HEADER_BYTES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [15:0] i_arena_size,
    input  logic        i_operation,
    input  logic [15:0] i_request_size,
    input  logic [15:0] i_release_offset,
    output t_stat       o_stat,
    output logic [15:0] o_payload,
    output logic        o_whole_free
);
    localparam int AW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam logic [16:0] HDR = 17'(HEADER_BYTES);

    // entry: {free, length, start}
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [32:0]   ram_wdata, ram_rdata;

    ffa_ram #(.WIDTH(33), .DEPTH(MAX_SEGMENTS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;     // scan / shift index
    logic [CW-1:0] r_hit, n_hit;
    logic          r_op;
    logic [15:0]   r_req, r_rel;
    logic [32:0]   r_cur, n_cur;     // hit entry
    logic [32:0]   r_prev, n_prev;   // entry before hit
    logic [32:0]   r_next, n_next;
    logic [32:0]   r_e0, n_e0;       // entry 0 shadow
    logic          r_pf, r_nf, n_pf, n_nf;
    logic [32:0]   r_ins, n_ins;     // entry to insert
    logic [1:0]    r_mode, n_mode;   // removals pending in free
    logic [CW-1:0] r_rm, n_rm;       // removal index

    logic        cur_free;
    logic [15:0] cur_len, cur_start;
    logic [16:0] need;
    logic        match;

    assign cur_free  = ram_rdata[32];
    assign cur_len   = ram_rdata[31:16];
    assign cur_start = ram_rdata[15:0];
    assign need      = {1'b0, r_req} + HDR;
    assign match     = (r_op == OP_FREE)
                       ? (({1'b0, cur_start} + HDR) == {1'b0, r_rel})
                       : (cur_free && ({1'b0, cur_len} >= need));

    always_comb begin
        o_stat.scan_hit    = match;
        o_stat.scan_end    = (r_idx + CW'(1) >= r_count);
        o_stat.table_full  = (r_count == CW'(MAX_SEGMENTS));
        o_stat.op_free     = r_op;
        o_stat.is_free_hit = cur_free;
        o_stat.shift_end   = (r_idx <= r_hit + CW'(1));
        o_stat.rem_end     = (r_mode == 2'd0) || (r_idx + CW'(r_mode) >= r_count);
    end

    assign o_payload    = r_cur[15:0] + 16'(HEADER_BYTES);
    assign o_whole_free = (r_count == CW'(1)) && r_e0[32];

    always_comb begin
        n_count = r_count; n_idx = r_idx; n_hit = r_hit;
        n_cur = r_cur; n_prev = r_prev; n_next = r_next; n_e0 = r_e0;
        n_pf = r_pf; n_nf = r_nf; n_ins = r_ins;
        n_mode = r_mode; n_rm = r_rm;
        ram_we = 1'b0; ram_waddr = '0; ram_wdata = '0;
        ram_raddr = r_idx[AW-1:0];
        unique case (i_cmd)
            CMD_INIT: begin
                ram_we = 1'b1;
                ram_wdata = {1'b1,
                    (i_arena_size > 16'(HEADER_BYTES)) ?
                        16'(i_arena_size - 16'(HEADER_BYTES)) : 16'd0, 16'd0};
                n_e0 = ram_wdata;
                n_count = CW'(1);
            end
            CMD_LOAD: begin
                n_idx = '0;
            end
            CMD_RD: ;
            CMD_SCAN_CHK: begin
                if (match) begin
                    n_hit = r_idx;
                    n_cur = ram_rdata;
                    n_idx = r_count;  // insertion shift starts at the top
                    // next neighbour for a free
                    ram_raddr = AW'(r_idx + CW'(1));
                end else begin
                    n_prev = ram_rdata;
                    n_idx = r_idx + CW'(1);
                end
            end
            CMD_ALLOC_WR: begin
                ram_we = 1'b1;
                ram_waddr = r_hit[AW-1:0];
                ram_wdata = {1'b0, r_req, r_cur[15:0]};
                n_ins = {1'b1, 16'(r_cur[31:16] - need[15:0]),
                         16'(r_cur[15:0] + 16'(HEADER_BYTES) + r_req)};
                if (r_hit == '0) n_e0 = ram_wdata;
                n_mode = 2'd0;
                ram_raddr = AW'(r_count - CW'(1));
            end
            CMD_INS_STEP: begin
                // ram_rdata holds entry r_idx-1
                if (r_idx > r_hit + CW'(1)) begin
                    ram_we = 1'b1;
                    ram_waddr = r_idx[AW-1:0];
                    ram_wdata = ram_rdata;
                    ram_raddr = AW'(r_idx - CW'(2));
                    n_idx = r_idx - CW'(1);
                end
            end
            CMD_INS_WR: begin
                ram_we = 1'b1;
                ram_waddr = AW'(r_hit + CW'(1));
                ram_wdata = r_ins;
                n_count = r_count + CW'(1);
            end
            CMD_FREE_RD: begin
                // ram_rdata holds entry r_hit+1, read issued on the scan hit
                n_next = ram_rdata;
                n_pf = (r_hit != '0) && r_prev[32];
                n_nf = (r_hit + CW'(1) < r_count) && ram_rdata[32];
            end
            CMD_FREE_WR: begin
                ram_we = 1'b1;
                if (r_pf) begin
                    ram_waddr = AW'(r_hit - CW'(1));
                    ram_wdata = {1'b1, 16'(r_prev[31:16] + r_cur[31:16]
                        + 16'(HEADER_BYTES)
                        + (r_nf ? 16'(r_next[31:16] + 16'(HEADER_BYTES)) : 16'd0)),
                        r_prev[15:0]};
                    n_rm = r_hit;
                    n_mode = r_nf ? 2'd2 : 2'd1;
                end else begin
                    ram_waddr = r_hit[AW-1:0];
                    ram_wdata = {1'b1, r_nf ? 16'(r_cur[31:16] + r_next[31:16]
                        + 16'(HEADER_BYTES)) : r_cur[31:16], r_cur[15:0]};
                    n_rm = r_hit + CW'(1);
                    n_mode = r_nf ? 2'd1 : 2'd0;
                end
                if (ram_waddr == '0) n_e0 = ram_wdata;
                n_idx = n_rm;
                ram_raddr = AW'(n_rm + CW'(n_mode));
            end
            CMD_REM_STEP: begin
                // ram_rdata holds entry r_idx + r_mode; write it at r_idx
                if ((r_mode != 2'd0) && (r_idx + CW'(r_mode) < r_count)) begin
                    ram_we = 1'b1;
                    ram_waddr = r_idx[AW-1:0];
                    ram_wdata = ram_rdata;
                    if (r_idx == '0) n_e0 = ram_rdata;
                    n_idx = r_idx + CW'(1);
                    ram_raddr = AW'(r_idx + CW'(1) + CW'(r_mode));
                end else begin
                    n_count = r_count - CW'(r_mode);
                    n_mode = 2'd0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= CW'(1);
            r_idx <= '0;
            r_mode <= '0;
        end else begin
            r_count <= n_count;
            r_idx <= n_idx;
            r_mode <= n_mode;
        end
        r_hit <= n_hit; r_cur <= n_cur; r_prev <= n_prev; r_next <= n_next;
        r_e0 <= n_e0; r_pf <= n_pf; r_nf <= n_nf; r_ins <= n_ins; r_rm <= n_rm;
        if (i_cmd == CMD_LOAD) begin
            r_op <= i_operation;
            r_req <= i_request_size;
            r_rel <= i_release_offset;
        end else begin
            r_op <= r_op; r_req <= r_req; r_rel <= r_rel;
        end
    end
endmodule

### rtl/ffa_ctrl.sv
// ffa_ctrl: sequencer for scan, insert shift, merge and remove shift
// depends on ffa_pkg
module ffa_ctrl
    import ffa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_valid,
    output logic        o_stall,
    output logic        o_valid,
    input  logic        i_stall,
    input  t_stat       i_stat,
    output t_cmd        o_cmd,
    output logic [1:0]  o_status,
    output logic        o_ok
);
    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_RD, S_CHK, S_AWR, S_INS, S_IWR, S_FRD, S_FWR, S_REM,
        S_OUT
    } t_state;

    t_state     r_state;
    logic [1:0] r_status;
    logic       r_ok;
    logic       out_busy;

    assign out_busy = o_valid && i_stall;
    assign o_stall  = !(r_state == S_IDLE) || out_busy || i_cfg_we;
    assign o_status = r_status;
    assign o_ok     = r_ok;

    always_comb begin
        unique case (r_state)
            S_INIT:  o_cmd = CMD_INIT;
            S_IDLE:  o_cmd = (i_valid && !o_stall) ? CMD_LOAD : CMD_NONE;
            S_RD:    o_cmd = CMD_RD;
            S_CHK:   o_cmd = CMD_SCAN_CHK;
            S_AWR:   o_cmd = CMD_ALLOC_WR;
            S_INS:   o_cmd = CMD_INS_STEP;
            S_IWR:   o_cmd = CMD_INS_WR;
            S_FRD:   o_cmd = CMD_FREE_RD;
            S_FWR:   o_cmd = CMD_FREE_WR;
            S_REM:   o_cmd = CMD_REM_STEP;
            default: o_cmd = CMD_NONE;
        endcase
        if (i_cfg_we) o_cmd = CMD_INIT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            o_valid <= 1'b0;
            r_status <= ST_OK;
            r_ok <= 1'b0;
        end else begin
            if (o_valid && !i_stall) o_valid <= 1'b0;
            if (i_cfg_we) begin
                r_state <= S_IDLE;
            end else begin
                unique case (r_state)
                    S_INIT: r_state <= S_IDLE;
                    S_IDLE: if (i_valid && !o_stall) r_state <= S_RD;
                    S_RD:   r_state <= S_CHK;
                    S_CHK: begin
                        if (i_stat.scan_hit) begin
                            if (i_stat.op_free) begin
                                if (i_stat.is_free_hit) begin
                                    r_status <= ST_BAD_FREE; r_ok <= 1'b0;
                                    r_state <= S_OUT;
                                end else begin
                                    r_state <= S_FRD;
                                end
                            end else if (i_stat.table_full) begin
                                r_status <= ST_FULL; r_ok <= 1'b0;
                                r_state <= S_OUT;
                            end else begin
                                r_state <= S_AWR;
                            end
                        end else if (i_stat.scan_end) begin
                            r_status <= i_stat.op_free ? ST_BAD_FREE : ST_NO_FIT;
                            r_ok <= 1'b0;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                    S_AWR:  r_state <= S_INS;
                    S_INS:  if (i_stat.shift_end) r_state <= S_IWR;
                    S_IWR: begin
                        r_status <= ST_OK; r_ok <= 1'b1; r_state <= S_OUT;
                    end
                    S_FRD:  r_state <= S_FWR;
                    S_FWR:  r_state <= S_REM;
                    // removal pass ends when the datapath has no entry left to move
                    S_REM: if (i_stat.rem_end) begin
                        r_status <= ST_OK; r_ok <= 1'b0; r_state <= S_OUT;
                    end
                    S_OUT: begin
                        if (!out_busy) begin
                            o_valid <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end
endmodule

### rtl/first_fit_arena_allocator_core.sv
// channel | direction | signals
// in      | input     | i_valid, o_stall, i_operation, i_request_size, i_release_offset
// out     | output    | o_valid, i_stall, o_status, o_payload_offset, o_whole_arena_free
// cfg     | input     | i_cfg_we, i_cfg_data (arena_size)
// an item scans the table entries in order and then runs the insert or remove shift
// through the table ram; o_stall holds new beats off while an item is in progress
// reset and each arena_size write rebuild entry 0
// the result waits in the output register while o_stall holds new beats off
module first_fit_arena_allocator_core
    import ffa_pkg::*;
#(
    parameter int MAX_SEGMENTS = 128,
    parameter int HEADER_BYTES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_operation,
    input  logic [15:0] i_request_size,
    input  logic [15:0] i_release_offset,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [15:0] o_payload_offset,
    output logic        o_whole_arena_free
);
    logic [15:0] r_arena;
    t_cmd        cmd;
    t_stat       stat;
    logic [1:0]  sts;
    logic        ok;
    logic [15:0] pay;
    logic        whole;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arena <= 16'd4096;
        end else if (i_cfg_we) begin
            r_arena <= i_cfg_data;
        end
    end

    ffa_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_valid(i_valid), .o_stall(o_stall), .o_valid(o_valid),
        .i_stall(i_stall), .i_stat(stat), .o_cmd(cmd),
        .o_status(sts), .o_ok(ok)
    );

    ffa_dp #(.MAX_SEGMENTS(MAX_SEGMENTS), .HEADER_BYTES(HEADER_BYTES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_arena_size(i_cfg_we ? i_cfg_data : r_arena),
        .i_operation(i_operation), .i_request_size(i_request_size),
        .i_release_offset(i_release_offset), .o_stat(stat),
        .o_payload(pay), .o_whole_free(whole)
    );

    assign o_status           = sts;
    assign o_payload_offset   = ok ? pay : 16'd0;
    assign o_whole_arena_free = whole;
endmodule

### sim/tb.sv
// tb: self-checking bench for first_fit_arena_allocator_core
// keeps its own segment table, drives alloc/free beats and compares every result
// depends on rtl/ffa_pkg.sv and rtl/first_fit_arena_allocator_core.sv
module tb
    import ffa_pkg::*;
;

    localparam int SEGS = 128;
    localparam int HDR = 32;
    localparam int LIMIT = 4000000;

    typedef struct packed {
        logic        op;
        logic [15:0] req;
        logic [15:0] rel;
    } t_beat;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] offset;
        logic        whole_free;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_operation = 1'b0;
    logic [15:0] i_request_size = '0;
    logic [15:0] i_release_offset = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_status;
    logic [15:0] o_payload_offset;
    logic        o_whole_arena_free;

    first_fit_arena_allocator_core #(.MAX_SEGMENTS(SEGS), .HEADER_BYTES(HDR)) DUT (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // shadow segment table
    logic [15:0] seg_start [SEGS];
    logic [15:0] seg_len [SEGS];
    logic        seg_free [SEGS];
    int          seg_cnt;
    logic [15:0] arena_bytes;

    t_beat   pending_beats[$];
    t_result expected_results[$];
    logic [15:0] live_offsets[$];
    int      n_errors = 0;
    int      cycles = 0;
    bit      quiet_mode = 1'b0;   // no idling on either side
    int      hold_cycles = 0;     // receiver hold-off counter
    bit      send_pause = 1'b0;
    bit      in_taken = 1'b0;     // input beat accepted at the last rising edge

    function automatic void table_reset(input logic [15:0] size);
        arena_bytes = size;
        seg_start[0] = '0;
        seg_len[0] = (size > HDR) ? 16'(size - HDR) : '0;
        seg_free[0] = 1'b1;
        seg_cnt = 1;
    endfunction

    function automatic void drop_entry(input int k);
        for (int j = k; j + 1 < seg_cnt; j++) begin
            seg_start[j] = seg_start[j+1];
            seg_len[j] = seg_len[j+1];
            seg_free[j] = seg_free[j+1];
        end
        seg_cnt--;
    endfunction

    function automatic t_result allocator_step(input t_beat b);
        t_result r;
        int i;
        int unsigned need, sum;
        r = '0;
        if (b.op == OP_ALLOC) begin
            need = b.req + HDR;
            for (i = 0; i < seg_cnt; i++)
                if (seg_free[i] && seg_len[i] >= need) break;
            if (i >= seg_cnt) r.status = ST_NO_FIT;
            else if (seg_cnt >= SEGS) r.status = ST_FULL;
            else begin
                for (int j = seg_cnt; j > i + 1; j--) begin
                    seg_start[j] = seg_start[j-1];
                    seg_len[j] = seg_len[j-1];
                    seg_free[j] = seg_free[j-1];
                end
                seg_start[i+1] = 16'(seg_start[i] + HDR + b.req);
                seg_len[i+1] = 16'(seg_len[i] - need);
                seg_free[i+1] = 1'b1;
                seg_cnt++;
                r.offset = 16'(seg_start[i] + HDR);
                seg_free[i] = 1'b0;
                seg_len[i] = b.req;
                r.status = ST_OK;
            end
        end else begin
            for (i = 0; i < seg_cnt; i++)
                if (32'(seg_start[i]) + HDR == 32'(b.rel)) break;
            if (i >= seg_cnt || seg_free[i]) r.status = ST_BAD_FREE;
            else begin
                bit pf, nf;
                pf = (i > 0) && seg_free[i-1];
                nf = (i + 1 < seg_cnt) && seg_free[i+1];
                if (pf && nf) begin
                    sum = seg_len[i-1] + seg_len[i] + seg_len[i+1] + 2 * HDR;
                    seg_len[i-1] = 16'(sum);
                    drop_entry(i + 1);
                    drop_entry(i);
                end else if (pf) begin
                    seg_len[i-1] = 16'(seg_len[i-1] + seg_len[i] + HDR);
                    drop_entry(i);
                end else if (nf) begin
                    seg_len[i] = 16'(seg_len[i] + seg_len[i+1] + HDR);
                    seg_free[i] = 1'b1;
                    drop_entry(i + 1);
                end else seg_free[i] = 1'b1;
                r.status = ST_OK;
            end
        end
        r.whole_free = (seg_cnt == 1) && seg_free[0];
        return r;
    endfunction

    // driver: next beat at falling edge once the current one is taken
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || in_taken) begin
                if (pending_beats.size() > 0 && !send_pause
                        && (quiet_mode || $urandom_range(99) >= 21)) begin
                    t_beat b;
                    b = pending_beats.pop_front();
                    i_operation <= b.op;
                    i_request_size <= b.req;
                    i_release_offset <= b.rel;
                    i_valid <= 1'b1;
                end else i_valid <= 1'b0;
            end
        end
    end

    // receiver: stall at falling edge, long hold-offs counted here
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_cycles > 0) begin
                i_stall <= 1'b1;
                hold_cycles <= hold_cycles - 1;
            end else i_stall <= !quiet_mode && ($urandom_range(99) < 21);
        end
    end

    // monitor: predict on accepted input, check on accepted output
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        in_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                t_result r;
                r = allocator_step('{i_operation, i_request_size, i_release_offset});
                expected_results.push_back(r);
                if (i_operation == OP_ALLOC && r.status == ST_OK)
                    live_offsets.push_back(r.offset);
            end
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t unexpected result: status %0d offset %0d whole %0b",
                             $time, o_status, o_payload_offset, o_whole_arena_free);
                    n_errors++;
                end else begin
                    t_result e;
                    e = expected_results.pop_front();
                    if (o_status !== e.status) begin
                        $display("%0t status expected %0d actual %0d",
                                 $time, e.status, o_status);
                        n_errors++;
                    end
                    if (o_payload_offset !== e.offset) begin
                        $display("%0t payload_offset expected %0d actual %0d",
                                 $time, e.offset, o_payload_offset);
                        n_errors++;
                    end
                    if (o_whole_arena_free !== e.whole_free) begin
                        $display("%0t whole_arena_free expected %0b actual %0b",
                                 $time, e.whole_free, o_whole_arena_free);
                        n_errors++;
                    end
                end
            end
        end
        if (cycles >= LIMIT) begin
            $display("[first_fit_arena_allocator_core] ERROR");
            $finish;
        end
    end

    task automatic queue_beat(input logic op, input logic [15:0] req, input logic [15:0] rel);
        pending_beats.push_back('{op, req, rel});
    endtask

    task automatic drain();
        wait (pending_beats.size() == 0);
        @(posedge i_clk);
        while (i_valid || expected_results.size() > 0) @(posedge i_clk);
        repeat (4 * SEGS + 20) @(posedge i_clk);
    endtask

    task automatic write_arena(input logic [15:0] size);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= size;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        table_reset(size);
        live_offsets.delete();
    endtask

    // random phase: mostly frees of live offsets and modest allocs, some noise
    task automatic random_phase(input int n, input int max_req);
        for (int k = 0; k < n; k++) begin
            int pick;
            pick = $urandom_range(99);
            if (pick < 45) queue_beat(OP_ALLOC, 16'($urandom_range(max_req)), 16'($urandom));
            else if (pick < 50) queue_beat(OP_ALLOC, 16'($urandom), 16'($urandom));
            else if (pick < 90) begin
                // wait until the driver has taken every queued beat before picking a live offset
                while (pending_beats.size() > 0) @(posedge i_clk);
                if (live_offsets.size() > 0) begin
                    int idx;
                    idx = $urandom_range(live_offsets.size() - 1);
                    queue_beat(OP_FREE, 16'($urandom), live_offsets[idx]);
                    if ($urandom_range(3) != 0) live_offsets.delete(idx);
                end else queue_beat(OP_FREE, 16'($urandom), 16'($urandom));
            end else queue_beat(OP_FREE, 16'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        table_reset(16'd4096);
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, both ops, no-fit and bad-free cases
        queue_beat(OP_FREE, 16'h0000, 16'h0020);   // double free of whole arena
        queue_beat(OP_ALLOC, 16'hFFFF, 16'hFFFF);  // no fit
        queue_beat(OP_ALLOC, 16'h0000, 16'h0000);  // zero request
        queue_beat(OP_ALLOC, 16'd100, 16'h0000);
        queue_beat(OP_ALLOC, 16'd200, 16'h0000);
        queue_beat(OP_FREE, 16'h0000, 16'd52);     // unknown offset
        queue_beat(OP_FREE, 16'h0000, 16'd52);     // unknown offset again
        queue_beat(OP_FREE, 16'h0000, 16'h0000);   // unknown offset
        queue_beat(OP_FREE, 16'h0000, 16'h0020);   // free first entry, next neighbour allocated so no merge
        queue_beat(OP_FREE, 16'h0000, 16'd184);    // unknown offset
        queue_beat(OP_ALLOC, 16'd4032, 16'h0000);  // no fit
        queue_beat(OP_FREE, 16'h0000, 16'h0020);
        drain();

        // tiny arenas: one just over the header size, one smaller than it
        write_arena(16'd33);
        queue_beat(OP_ALLOC, 16'd0, 16'd0);
        queue_beat(OP_ALLOC, 16'd1, 16'd0);
        drain();
        write_arena(16'd16);
        queue_beat(OP_ALLOC, 16'd0, 16'd0);
        queue_beat(OP_FREE, 16'd0, 16'd32);
        drain();

        // table full: many zero allocs in a large arena
        write_arena(16'hFFFF);
        for (int k = 0; k < SEGS + 2; k++) queue_beat(OP_ALLOC, 16'd0, 16'd0);
        drain();

        // long receiver hold-off while the sender keeps offering
        write_arena(16'd4096);
        hold_cycles = 3000;
        random_phase(60, 200);
        drain();

        write_arena(16'd2000);
        random_phase(400, 120);
        // sender pause until all results are in
        send_pause = 1'b1;
        wait (!i_valid && expected_results.size() == 0);
        send_pause = 1'b0;
        drain();

        write_arena(16'hFFFF);
        random_phase(500, 3000);
        drain();

        quiet_mode = 1'b1;
        write_arena(16'd800);
        random_phase(300, 60);
        drain();
        quiet_mode = 1'b0;

        write_arena(16'd12000);
        random_phase(500, 600);
        drain();

        if (n_errors == 0) $display("[first_fit_arena_allocator_core] OK");
        else $display("[first_fit_arena_allocator_core] ERROR");
        $finish;
    end
endmodule

### first_fit_arena_allocator_core.f
rtl/ffa_pkg.sv
rtl/ffa_ram.sv
rtl/ffa_dp.sv
rtl/ffa_ctrl.sv
rtl/first_fit_arena_allocator_core.sv
sim/tb.sv
